// ===== hdl/apu_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and register codes of the Adam parameter update unit.
package apu_pkg;

    localparam int NUM_ELEMS  = 4096;  // moment memory depth, a power of two
    localparam int ADDR_W     = (NUM_ELEMS > 1) ? $clog2(NUM_ELEMS) : 1;

    localparam int IDX_W      = 12;
    localparam int VAL_W      = 32;
    localparam int LR_W       = 24;
    localparam int BETA_W     = 16;
    localparam int EPS_W      = 24;
    localparam int POW_W      = 32;
    localparam int SR_W       = 40;
    localparam int SC_W       = 41;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;

    localparam int DIV_STEPS  = 56;    // correction divider, one quotient bit a cycle
    localparam int CNT_W      = 6;
    localparam int SQ_STEPS   = 32;    // root pipeline, one root bit a stage
    localparam int QDIV_STEPS = 56;    // normalizing divide pipeline, one bit a stage

    localparam logic [LR_W-1:0]   LR_RESET  = 24'd16777;
    localparam logic [BETA_W-1:0] B1_RESET  = 16'd58982;
    localparam logic [BETA_W-1:0] B2_RESET  = 16'd65470;
    localparam logic [EPS_W-1:0]  EPS_RESET = 24'd1;

    localparam logic [POW_W-1:0]  POW_ONE   = 32'h8000_0000;
    localparam logic [SR_W-1:0]   SR_MAX    = {SR_W{1'b1}};
    localparam logic [SC_W-1:0]   SC_MAX    = {SC_W{1'b1}};
    localparam logic [SC_W-1:0]   SC_RESET  = SC_W'(64'd1 << 24);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEARN_RATE = 2'd0,
        CFG_BETA_ONE   = 2'd1,
        CFG_BETA_TWO   = 2'd2,
        CFG_EPSILON    = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [LR_W-1:0]   learn_rate;
        logic [BETA_W-1:0] beta_one;
        logic [BETA_W-1:0] beta_two;
        logic [EPS_W-1:0]  epsilon;
    } cfg_t;

    typedef struct packed {
        logic [IDX_W-1:0]        idx;
        logic signed [VAL_W-1:0] param;
        logic signed [VAL_W-1:0] grad;
        logic [SR_W-1:0]         step_rate;
        logic [SC_W-1:0]         second_corr;
    } qitem_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

// ===== hdl/apu_ifs.sv =====
`timescale 1ns / 1ps
// Input and output stream interfaces of the Adam parameter update unit.
interface apu_in_if;
    logic                             valid;
    logic                             ready;
    logic [apu_pkg::IDX_W-1:0]        elem_index;
    logic signed [apu_pkg::VAL_W-1:0] param_value;
    logic signed [apu_pkg::VAL_W-1:0] gradient;
    logic                             first_of_step;

    modport source (output valid, elem_index, param_value, gradient, first_of_step,
                    input ready);
    modport sink   (input valid, elem_index, param_value, gradient, first_of_step,
                    output ready);
endinterface

interface apu_out_if;
    logic                             valid;
    logic                             ready;
    logic [apu_pkg::IDX_W-1:0]        out_index;
    logic signed [apu_pkg::VAL_W-1:0] new_param_value;

    modport source (output valid, out_index, new_param_value, input ready);
    modport sink   (input valid, out_index, new_param_value, output ready);
endinterface

// ===== hdl/apu_ram.sv =====
`timescale 1ns / 1ps
// Generic single write port RAM with registered read, old data on collision.
module apu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

// ===== hdl/apu_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts beats, advances beta powers and recomputes bias corrections.
module apu_front (
    input  logic                clk,
    input  logic                rst_n,
    apu_in_if.sink              in_ch,
    input  apu_pkg::cfg_t       cfg,
    input  logic                clearing,
    input  apu_pkg::fifo_stat_t fstat,
    output logic                push,
    output apu_pkg::qitem_t     push_item
);

    typedef enum logic [2:0] {
        ST_RUN = 3'b001,
        ST_POW = 3'b010,
        ST_DIV = 3'b100
    } front_state_t;

    front_state_t state_reg, state_next;

    apu_pkg::qitem_t hold_reg;
    logic [apu_pkg::POW_W-1:0] pow1_reg, pow2_reg;
    logic [apu_pkg::SR_W-1:0]  sr_reg;
    logic [apu_pkg::SC_W-1:0]  sc_reg;
    logic [apu_pkg::CNT_W-1:0] cnt_reg;
    logic [31:0] rem1_reg, rem2_reg;
    logic [55:0] dvd1_reg, dvd2_reg, quo1_reg, quo2_reg;

    logic        take;
    logic        div_last;
    logic        div_done;
    logic [47:0] prod1, prod2;
    logic [31:0] d1, d2;
    logic [32:0] trial1, trial2;
    logic        ge1, ge2;
    logic [31:0] rem1_next, rem2_next;
    logic [55:0] qf1, qf2;
    logic [apu_pkg::SR_W-1:0] sr_next;
    logic [apu_pkg::SC_W-1:0] sc_next;

    assign in_ch.ready = (state_reg == ST_RUN) && !fstat.full && !clearing;
    assign take        = in_ch.valid && in_ch.ready;

    assign prod1 = pow1_reg * cfg.beta_one;
    assign prod2 = pow2_reg * cfg.beta_two;
    assign d1    = apu_pkg::POW_ONE - pow1_reg;
    assign d2    = apu_pkg::POW_ONE - pow2_reg;

    // restoring divide step, both corrections side by side
    assign trial1    = {rem1_reg, dvd1_reg[55]};
    assign trial2    = {rem2_reg, dvd2_reg[55]};
    assign ge1       = trial1 >= {1'b0, d1};
    assign ge2       = trial2 >= {1'b0, d2};
    assign rem1_next = ge1 ? 32'(trial1 - {1'b0, d1}) : trial1[31:0];
    assign rem2_next = ge2 ? 32'(trial2 - {1'b0, d2}) : trial2[31:0];
    assign qf1       = {quo1_reg[54:0], ge1};
    assign qf2       = {quo2_reg[54:0], ge2};

    // hold the last divide step until the queue has room for the flagged beat
    assign div_last = (state_reg == ST_DIV) &&
                      (cnt_reg == apu_pkg::CNT_W'(apu_pkg::DIV_STEPS - 1));
    assign div_done = div_last && !fstat.full;

    always_comb
    begin
        if (d1 == '0 || qf1 > {16'b0, apu_pkg::SR_MAX})
        begin
            sr_next = apu_pkg::SR_MAX;
        end
        else
        begin
            sr_next = qf1[apu_pkg::SR_W-1:0];
        end
        if (d2 == '0 || qf2 > {15'b0, apu_pkg::SC_MAX})
        begin
            sc_next = apu_pkg::SC_MAX;
        end
        else
        begin
            sc_next = qf2[apu_pkg::SC_W-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_RUN:
            begin
                if (take && in_ch.first_of_step)
                begin
                    state_next = ST_POW;
                end
            end
            ST_POW:  state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_RUN;
                end
            end
            default: state_next = ST_RUN;
        endcase
    end

    // flagged beat waits in the hold register until its corrections are ready
    assign push = (take && !in_ch.first_of_step) || div_done;

    always_comb
    begin
        if (div_done)
        begin
            push_item             = hold_reg;
            push_item.step_rate   = sr_next;
            push_item.second_corr = sc_next;
        end
        else
        begin
            push_item.idx         = in_ch.elem_index;
            push_item.param       = in_ch.param_value;
            push_item.grad        = in_ch.gradient;
            push_item.step_rate   = sr_reg;
            push_item.second_corr = sc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
            pow1_reg  <= apu_pkg::POW_ONE;
            pow2_reg  <= apu_pkg::POW_ONE;
            sr_reg    <= '0;
            sc_reg    <= apu_pkg::SC_RESET;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_POW:
                begin
                    pow1_reg <= prod1[47:16];
                    pow2_reg <= prod2[47:16];
                    cnt_reg  <= '0;
                end
                ST_DIV:
                begin
                    if (!div_last)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    if (div_done)
                    begin
                        sr_reg <= sr_next;
                        sc_reg <= sc_next;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hold_reg <= push_item;
        end
        case (state_reg)
            ST_POW:
            begin
                rem1_reg <= '0;
                rem2_reg <= '0;
                quo1_reg <= '0;
                quo2_reg <= '0;
                dvd1_reg <= {1'b0, cfg.learn_rate, 31'b0};
                dvd2_reg <= {1'b1, 55'b0};
            end
            ST_DIV:
            begin
                if (!div_last)
                begin
                    rem1_reg <= rem1_next;
                    rem2_reg <= rem2_next;
                    quo1_reg <= qf1;
                    quo2_reg <= qf2;
                    dvd1_reg <= {dvd1_reg[54:0], 1'b0};
                    dvd2_reg <= {dvd2_reg[54:0], 1'b0};
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== hdl/apu_queue.sv =====
`timescale 1ns / 1ps
// Short queue between the front end and the update pipeline.
module apu_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  apu_pkg::qitem_t     push_item,
    input  logic                pop,
    output apu_pkg::qitem_t     head,
    output apu_pkg::fifo_stat_t fstat
);

    apu_pkg::qitem_t mem_reg [apu_pkg::FIFO_DEPTH];
    logic [apu_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [apu_pkg::FIFO_PTR_W:0]   cnt_reg;
    logic do_push, do_pop;

    assign fstat.full  = (cnt_reg == (apu_pkg::FIFO_PTR_W + 1)'(apu_pkg::FIFO_DEPTH));
    assign fstat.empty = (cnt_reg == '0);
    assign do_push     = push && !fstat.full;
    assign do_pop      = pop && !fstat.empty;
    assign head        = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== hdl/apu_back.sv =====
`timescale 1ns / 1ps
// Update pipeline: moment read-modify-write, root, normalizing divide, step apply.
module apu_back (
    input  logic                clk,
    input  logic                rst_n,
    input  apu_pkg::cfg_t       cfg,
    input  apu_pkg::qitem_t     head,
    input  apu_pkg::fifo_stat_t fstat,
    output logic                pop,
    output logic                clearing,
    apu_out_if.source           out_ch
);

    typedef struct packed {
        logic [apu_pkg::IDX_W-1:0] idx;
        logic signed [31:0]        param;
        logic                      mneg;
        logic [31:0]               mmag;
        logic [apu_pkg::SR_W-1:0]  step_rate;
    } pay_t;

    typedef struct packed {
        logic [apu_pkg::IDX_W-1:0] idx;
        logic signed [31:0]        param;
        logic signed [31:0]        grad;
        logic [31:0]               g2;
        logic [apu_pkg::SR_W-1:0]  sr;
        logic [apu_pkg::SC_W-1:0]  sc;
    } s1_t;

    typedef struct packed {
        pay_t                     pay;
        logic [31:0]              vv;
        logic [apu_pkg::SC_W-1:0] sc;
    } s2_t;

    typedef struct packed {
        pay_t        pay;
        logic [55:0] plo;
        logic [48:0] phi;
    } s3_t;

    typedef struct packed {
        pay_t        pay;
        logic [39:0] a;
    } s4_t;

    typedef struct packed {
        pay_t        pay;
        logic [63:0] x;
        logic [33:0] rem;
        logic [31:0] root;
    } sq_t;

    typedef struct packed {
        pay_t        pay;
        logic [55:0] dvd;
        logic [31:0] rem;
        logic [55:0] quo;
        logic [31:0] dsr;
    } dv_t;

    typedef struct packed {
        pay_t        pay;
        logic [63:0] pll;
        logic [55:0] plh;
        logic [39:0] phl;
        logic [31:0] phh;
    } m1_t;

    typedef struct packed {
        logic [apu_pkg::IDX_W-1:0] idx;
        logic signed [31:0]        param;
        logic                      mneg;
        logic [34:0]               delta;
    } m2_t;

    localparam logic [34:0] STEP_CAP = 35'd1 << 34;

    function automatic sq_t sqrt_step(input sq_t cur);
        sq_t         nxt;
        logic [35:0] rem2;
        logic [35:0] trial;
        logic        ge;
        nxt      = cur;
        rem2     = {cur.rem, cur.x[63:62]};
        trial    = {2'b00, cur.root, 2'b01};
        ge       = rem2 >= trial;
        nxt.rem  = ge ? 34'(rem2 - trial) : rem2[33:0];
        nxt.root = {cur.root[30:0], ge};
        nxt.x    = {cur.x[61:0], 2'b00};
        return nxt;
    endfunction

    function automatic dv_t div_step(input dv_t cur);
        dv_t         nxt;
        logic [32:0] trial;
        logic        ge;
        nxt     = cur;
        trial   = {cur.rem, cur.dvd[55]};
        ge      = trial >= {1'b0, cur.dsr};
        nxt.rem = ge ? 32'(trial - {1'b0, cur.dsr}) : trial[31:0];
        nxt.quo = {cur.quo[54:0], ge};
        nxt.dvd = {cur.dvd[54:0], 1'b0};
        return nxt;
    endfunction

    logic en;
    logic clearing_reg;
    logic [apu_pkg::ADDR_W-1:0] clr_cnt_reg;

    s1_t s1_reg;
    s2_t s2_reg;
    s3_t s3_reg;
    s4_t s4_reg;
    sq_t sq_reg [apu_pkg::SQ_STEPS+1];
    dv_t dv_reg [apu_pkg::QDIV_STEPS+1];
    m1_t m1_reg;
    m2_t m2_reg;
    logic s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg, m1_v_reg, m2_v_reg, out_v_reg;
    logic [apu_pkg::SQ_STEPS:0]   sq_v_reg;
    logic [apu_pkg::QDIV_STEPS:0] dv_v_reg;

    logic                       fwd_v_reg;
    logic [apu_pkg::ADDR_W-1:0] fwd_addr_reg;
    logic [31:0]                fwd_m_reg, fwd_s_reg;

    logic [apu_pkg::IDX_W-1:0]        out_index_reg;
    logic signed [apu_pkg::VAL_W-1:0] out_value_reg;

    // entry
    logic [31:0] gmag;
    logic [63:0] gsq;
    logic [31:0] g2;
    logic [apu_pkg::ADDR_W-1:0] rd_addr;

    // moment update
    logic [apu_pkg::ADDR_W-1:0] s1_addr;
    logic               fwd_hit;
    logic [31:0]        m_q, s_q;
    logic signed [31:0] m_old;
    logic [31:0]        v_old;
    logic [16:0]        nb1, nb2;
    logic signed [50:0] m_sum;
    logic [49:0]        v_sum;
    logic signed [31:0] m_new;
    logic [31:0]        v_new;
    pay_t               s1_pay;

    logic                       ram_we;
    logic [apu_pkg::ADDR_W-1:0] ram_waddr;
    logic [31:0]                m_wdata, s_wdata;

    logic [49:0] asum;
    logic [39:0] a_sat;
    logic [40:0] ssum;
    logic [39:0] s_sat;
    sq_t         sq_init;
    dv_t         dv_init;
    logic [55:0] qv;
    logic [56:0] mid;
    logic [95:0] total;
    logic [34:0] delta;
    logic signed [36:0] res_wide;
    logic signed [31:0] res_sat;

    assign clearing = clearing_reg;
    assign en       = !out_v_reg || out_ch.ready;
    assign pop      = en && !fstat.empty && !clearing_reg;

    assign gmag    = head.grad[31] ? (~head.grad + 32'd1) : head.grad;
    assign gsq     = gmag * gmag;
    assign g2      = (|gsq[63:56]) ? 32'hFFFF_FFFF : gsq[55:24];
    assign rd_addr = apu_pkg::ADDR_W'(head.idx);

    // the beat one stage ahead wrote at the same edge this read was taken
    assign s1_addr = apu_pkg::ADDR_W'(s1_reg.idx);
    assign fwd_hit = fwd_v_reg && (fwd_addr_reg == s1_addr);
    assign m_old   = fwd_hit ? $signed(fwd_m_reg) : $signed(m_q);
    assign v_old   = fwd_hit ? fwd_s_reg : s_q;
    assign nb1     = 17'h1_0000 - {1'b0, cfg.beta_one};
    assign nb2     = 17'h1_0000 - {1'b0, cfg.beta_two};
    assign m_sum   = $signed({2'b00, cfg.beta_one}) * m_old
                   + $signed({1'b0, nb1}) * $signed(s1_reg.grad);
    assign v_sum   = cfg.beta_two * v_old + nb2 * s1_reg.g2;
    assign m_new   = m_sum[47:16];
    assign v_new   = v_sum[47:16];

    assign s1_pay.idx       = s1_reg.idx;
    assign s1_pay.param     = s1_reg.param;
    assign s1_pay.mneg      = m_new[31];
    assign s1_pay.mmag      = m_new[31] ? (~m_new + 32'd1) : m_new;
    assign s1_pay.step_rate = s1_reg.sr;

    assign ram_we    = clearing_reg || (en && s1_v_reg);
    assign ram_waddr = clearing_reg ? clr_cnt_reg : s1_addr;
    assign m_wdata   = clearing_reg ? 32'd0 : m_new;
    assign s_wdata   = clearing_reg ? 32'd0 : v_new;

    apu_ram #(.WIDTH(32), .DEPTH(apu_pkg::NUM_ELEMS)) u_first_mem (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (m_wdata),
        .re    (en),
        .raddr (rd_addr),
        .rdata (m_q)
    );

    apu_ram #(.WIDTH(32), .DEPTH(apu_pkg::NUM_ELEMS)) u_second_mem (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_wdata),
        .re    (en),
        .raddr (rd_addr),
        .rdata (s_q)
    );

    // corrected second moment plus epsilon, both saturated
    assign asum  = 50'(s3_reg.phi) + 50'(s3_reg.plo[55:24]);
    assign a_sat = (asum > 50'(apu_pkg::SR_MAX)) ? apu_pkg::SR_MAX : asum[39:0];
    assign ssum  = {1'b0, s4_reg.a} + 41'(cfg.epsilon);
    assign s_sat = ssum[40] ? apu_pkg::SR_MAX : ssum[39:0];

    assign sq_init.pay  = s4_reg.pay;
    assign sq_init.x    = {s_sat, 24'b0};
    assign sq_init.rem  = '0;
    assign sq_init.root = '0;

    assign dv_init.pay = sq_reg[apu_pkg::SQ_STEPS].pay;
    assign dv_init.dvd = {sq_reg[apu_pkg::SQ_STEPS].pay.mmag, 24'b0};
    assign dv_init.rem = '0;
    assign dv_init.quo = '0;
    assign dv_init.dsr = (sq_reg[apu_pkg::SQ_STEPS].root == '0) ?
                         32'd1 : sq_reg[apu_pkg::SQ_STEPS].root;

    assign qv = dv_reg[apu_pkg::QDIV_STEPS].quo;

    // step size from the four registered partial products
    assign mid   = 57'(m1_reg.plh) + 57'(m1_reg.phl);
    assign total = 96'(m1_reg.pll) + (96'(mid) << 32) + (96'(m1_reg.phh) << 64);
    assign delta = (total[95:24] > 72'(STEP_CAP)) ? STEP_CAP : total[58:24];

    assign res_wide = m2_reg.mneg ? (37'(m2_reg.param) + $signed({2'b00, m2_reg.delta}))
                                  : (37'(m2_reg.param) - $signed({2'b00, m2_reg.delta}));

    always_comb
    begin
        if (res_wide > 37'sd2147483647)
        begin
            res_sat = 32'sh7FFF_FFFF;
        end
        else if (res_wide < -37'sd2147483648)
        begin
            res_sat = 32'sh8000_0000;
        end
        else
        begin
            res_sat = res_wide[31:0];
        end
    end

    assign out_ch.valid           = out_v_reg;
    assign out_ch.out_index       = out_index_reg;
    assign out_ch.new_param_value = out_value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            fwd_v_reg    <= 1'b0;
            s1_v_reg     <= 1'b0;
            s2_v_reg     <= 1'b0;
            s3_v_reg     <= 1'b0;
            s4_v_reg     <= 1'b0;
            sq_v_reg     <= '0;
            dv_v_reg     <= '0;
            m1_v_reg     <= 1'b0;
            m2_v_reg     <= 1'b0;
            out_v_reg    <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == apu_pkg::ADDR_W'(apu_pkg::NUM_ELEMS - 1))
                begin
                    clearing_reg <= 1'b0;
                end
            end
            if (en)
            begin
                fwd_v_reg <= s1_v_reg;
                s1_v_reg  <= pop;
                s2_v_reg  <= s1_v_reg;
                s3_v_reg  <= s2_v_reg;
                s4_v_reg  <= s3_v_reg;
                sq_v_reg  <= {sq_v_reg[apu_pkg::SQ_STEPS-1:0], s4_v_reg};
                dv_v_reg  <= {dv_v_reg[apu_pkg::QDIV_STEPS-1:0], sq_v_reg[apu_pkg::SQ_STEPS]};
                m1_v_reg  <= dv_v_reg[apu_pkg::QDIV_STEPS];
                m2_v_reg  <= m1_v_reg;
                out_v_reg <= m2_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg.idx   <= head.idx;
            s1_reg.param <= head.param;
            s1_reg.grad  <= head.grad;
            s1_reg.g2    <= g2;
            s1_reg.sr    <= head.step_rate;
            s1_reg.sc    <= head.second_corr;

            fwd_addr_reg <= s1_addr;
            fwd_m_reg    <= m_new;
            fwd_s_reg    <= v_new;

            s2_reg.pay <= s1_pay;
            s2_reg.vv  <= v_new;
            s2_reg.sc  <= s1_reg.sc;

            s3_reg.pay <= s2_reg.pay;
            s3_reg.plo <= s2_reg.vv * s2_reg.sc[23:0];
            s3_reg.phi <= s2_reg.vv * s2_reg.sc[40:24];

            s4_reg.pay <= s3_reg.pay;
            s4_reg.a   <= a_sat;

            sq_reg[0] <= sq_init;
            for (int k = 0; k < apu_pkg::SQ_STEPS; k++)
            begin
                sq_reg[k+1] <= sqrt_step(sq_reg[k]);
            end

            dv_reg[0] <= dv_init;
            for (int k = 0; k < apu_pkg::QDIV_STEPS; k++)
            begin
                dv_reg[k+1] <= div_step(dv_reg[k]);
            end

            m1_reg.pay <= dv_reg[apu_pkg::QDIV_STEPS].pay;
            m1_reg.pll <= dv_reg[apu_pkg::QDIV_STEPS].pay.step_rate[31:0] * qv[31:0];
            m1_reg.plh <= dv_reg[apu_pkg::QDIV_STEPS].pay.step_rate[31:0] * qv[55:32];
            m1_reg.phl <= dv_reg[apu_pkg::QDIV_STEPS].pay.step_rate[39:32] * qv[31:0];
            m1_reg.phh <= dv_reg[apu_pkg::QDIV_STEPS].pay.step_rate[39:32] * qv[55:32];

            m2_reg.idx   <= m1_reg.pay.idx;
            m2_reg.param <= m1_reg.pay.param;
            m2_reg.mneg  <= m1_reg.pay.mneg;
            m2_reg.delta <= delta;

            out_index_reg <= m2_reg.idx;
            out_value_reg <= res_sat;
        end
    end

endmodule

// ===== hdl/adam_param_update_unit.sv =====
`timescale 1ns / 1ps
// Top level of the Adam parameter update unit: registers, front end, queue, pipeline.
// A beat flagged first_of_step holds off the input while the divider runs, and longer
// while the queue is full. Throughput: one beat per cycle otherwise while the output
// is ready, set by the fully pipelined root and divide.
// Reset: after rst_n releases, a clearing pass zeroes both 4096-entry moment memories
// with input held off; configuration writes are taken throughout.
module adam_param_update_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    apu_in_if.sink                            in_ch,
    apu_out_if.source                         out_ch,
    input  logic                              cfg_we,
    input  logic [apu_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [apu_pkg::CFG_DATA_W-1:0]    cfg_data
);

    apu_pkg::cfg_t       cfg_reg;
    apu_pkg::qitem_t     q_push_item, q_head;
    apu_pkg::fifo_stat_t fstat;
    logic                q_push, q_pop;
    logic                clearing;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.learn_rate <= apu_pkg::LR_RESET;
            cfg_reg.beta_one   <= apu_pkg::B1_RESET;
            cfg_reg.beta_two   <= apu_pkg::B2_RESET;
            cfg_reg.epsilon    <= apu_pkg::EPS_RESET;
        end
        else if (cfg_we)
        begin
            case (apu_pkg::cfg_index_t'(cfg_index))
                apu_pkg::CFG_LEARN_RATE: cfg_reg.learn_rate <= cfg_data[apu_pkg::LR_W-1:0];
                apu_pkg::CFG_BETA_ONE:   cfg_reg.beta_one   <= cfg_data[apu_pkg::BETA_W-1:0];
                apu_pkg::CFG_BETA_TWO:   cfg_reg.beta_two   <= cfg_data[apu_pkg::BETA_W-1:0];
                apu_pkg::CFG_EPSILON:    cfg_reg.epsilon    <= cfg_data[apu_pkg::EPS_W-1:0];
                default: ;
            endcase
        end
    end

    apu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cfg       (cfg_reg),
        .clearing  (clearing),
        .fstat     (fstat),
        .push      (q_push),
        .push_item (q_push_item)
    );

    apu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .pop       (q_pop),
        .head      (q_head),
        .fstat     (fstat)
    );

    apu_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .head     (q_head),
        .fstat    (fstat),
        .pop      (q_pop),
        .clearing (clearing),
        .out_ch   (out_ch)
    );

    // the pipeline holds nothing while the memories are swept
    a_no_result_while_clearing : assert property (
        @(posedge clk) disable iff (!rst_n) clearing |-> !out_ch.valid)
        else $error("result beat during moment clearing pass");

    a_no_push_when_full : assert property (
        @(posedge clk) disable iff (!rst_n) q_push |-> !fstat.full)
        else $error("queue push while full");

    a_no_pop_when_empty : assert property (
        @(posedge clk) disable iff (!rst_n) q_pop |-> !fstat.empty)
        else $error("queue pop while empty");

    a_accept_implies_push : assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && !in_ch.first_of_step) |-> q_push)
        else $error("accepted beat not queued");

endmodule
